FILE: rtl/gcsr_pkg.sv
// Shared types and constants for the gain / clip stage with capture ring.
// No dependencies; RTL files use scoped names, the bench files import it.
package gcsr_pkg;

	localparam int SAMPLE_W = 24;
	localparam int GAIN_W   = 16;
	localparam int AGE_W    = 13;
	localparam int OUT_W    = 26;
	localparam int GAINED_W = 28;
	localparam int LIM_W    = 22;
	localparam int ENTRY_W  = SAMPLE_W + 1;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic signed [GAINED_W-1:0] FULL_SCALE_POS = 28'sd1048576;
	localparam logic signed [GAINED_W-1:0] FULL_SCALE_NEG = -28'sd1048576;
	localparam logic signed [GAINED_W-1:0] Q3_MAX         = 28'sd8388607;
	localparam logic signed [GAINED_W-1:0] Q3_MIN         = -28'sd8388608;
	localparam logic [GAIN_W-1:0]          UNITY_GAIN     = 16'd4096;

	typedef enum logic {
		REQ_PROCESS = 1'b0,
		REQ_READ    = 1'b1
	} req_kind_t;

	typedef enum logic {
		REG_INPUT_GAIN  = 1'b0,
		REG_OUTPUT_GAIN = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic valid;
		logic rd;
		logic ch;
		logic clip;
	} ctl_t;

endpackage

FILE: rtl/gcsr_regs.sv
// APB-style register file holding the input and output gains.
// Depends on gcsr_pkg.
module gcsr_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gcsr_pkg::ADDR_W-1:0]  paddr,
	input  logic [gcsr_pkg::DATA_W-1:0]  pwdata,
	output logic [gcsr_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output logic [gcsr_pkg::GAIN_W-1:0]  input_gain,
	output logic [gcsr_pkg::GAIN_W-1:0]  output_gain
);

	logic [gcsr_pkg::GAIN_W-1:0] in_gain_q;
	logic [gcsr_pkg::GAIN_W-1:0] out_gain_q;
	gcsr_pkg::reg_idx_t          idx;
	logic                        wr_en;

	assign idx    = gcsr_pkg::reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_gain_q  <= gcsr_pkg::UNITY_GAIN;
			out_gain_q <= gcsr_pkg::UNITY_GAIN;
		end else if (wr_en) begin
			unique case (idx)
				gcsr_pkg::REG_INPUT_GAIN:  in_gain_q  <= pwdata[gcsr_pkg::GAIN_W-1:0];
				gcsr_pkg::REG_OUTPUT_GAIN: out_gain_q <= pwdata[gcsr_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			gcsr_pkg::REG_INPUT_GAIN:
				prdata = {{(gcsr_pkg::DATA_W-gcsr_pkg::GAIN_W){1'b0}}, in_gain_q};
			gcsr_pkg::REG_OUTPUT_GAIN:
				prdata = {{(gcsr_pkg::DATA_W-gcsr_pkg::GAIN_W){1'b0}}, out_gain_q};
			default:
				prdata = '0;
		endcase
	end

	assign input_gain  = in_gain_q;
	assign output_gain = out_gain_q;

endmodule

FILE: rtl/gcsr_front.sv
// Front stages: input gain, rounding, clip detection, limit and store saturation,
// and reduction of the read age modulo the ring depth. Depends on gcsr_pkg.
module gcsr_front #(
	parameter int DEPTH = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                acc,
	input  logic                                req_type,
	input  logic                                channel,
	input  logic signed [gcsr_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [gcsr_pkg::AGE_W-1:0]          age,
	input  logic [gcsr_pkg::GAIN_W-1:0]         input_gain,
	output gcsr_pkg::ctl_t                      ctl_s3,
	output logic signed [gcsr_pkg::LIM_W-1:0]   lim_s3,
	output logic [gcsr_pkg::SAMPLE_W-1:0]       st_s3,
	output logic [$clog2(DEPTH)-1:0]            age_mod_s3
);

	localparam int PW       = $clog2(DEPTH);
	localparam int RECIP_W  = 27;
	localparam int QPROD_W  = gcsr_pkg::AGE_W + RECIP_W;
	localparam int Q_W      = QPROD_W - 30;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** 30) / DEPTH + 1);
	localparam int PROD_W   = gcsr_pkg::SAMPLE_W + gcsr_pkg::GAIN_W;

	gcsr_pkg::ctl_t                        ctl_s1;
	logic signed [gcsr_pkg::SAMPLE_W-1:0]  sample_s1;
	logic [gcsr_pkg::AGE_W-1:0]            age_s1;

	gcsr_pkg::ctl_t                        ctl_s2;
	logic signed [gcsr_pkg::GAINED_W-1:0]  gained_s2;
	logic [Q_W-1:0]                        q_s2;
	logic [gcsr_pkg::AGE_W-1:0]            age_s2;

	logic signed [PROD_W-1:0]              prod;
	logic signed [PROD_W-1:0]              prod_rnd;
	logic [QPROD_W-1:0]                    qprod;
	logic                                  over;
	logic                                  under;
	logic signed [gcsr_pkg::LIM_W-1:0]     lim;
	logic [gcsr_pkg::SAMPLE_W-1:0]         st;
	logic [gcsr_pkg::AGE_W-1:0]            age_rem;
	logic [gcsr_pkg::AGE_W+PW-1:0]         age_wide;

	// stage 1: capture the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= acc;
			ctl_s1.rd    <= (req_type == gcsr_pkg::REQ_READ);
			ctl_s1.ch    <= channel;
			ctl_s1.clip  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1 <= sample_in;
			age_s1    <= age;
		end
	end

	assign prod     = sample_s1 * $signed({1'b0, input_gain});
	assign prod_rnd = prod + PROD_W'(2048);
	assign qprod    = QPROD_W'(age_s1) * QPROD_W'(RECIP);

	// stage 2: rounded gained sample and age quotient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gained_s2 <= prod_rnd[PROD_W-1:12];
			q_s2      <= qprod[QPROD_W-1:30];
			age_s2    <= age_s1;
		end
	end

	assign over  = gained_s2 > gcsr_pkg::FULL_SCALE_POS;
	assign under = gained_s2 < gcsr_pkg::FULL_SCALE_NEG;

	always_comb begin
		priority if (over)
			lim = gcsr_pkg::LIM_W'(gcsr_pkg::FULL_SCALE_POS);
		else if (under)
			lim = gcsr_pkg::LIM_W'(gcsr_pkg::FULL_SCALE_NEG);
		else
			lim = gained_s2[gcsr_pkg::LIM_W-1:0];
	end

	always_comb begin
		priority if (gained_s2 > gcsr_pkg::Q3_MAX)
			st = gcsr_pkg::Q3_MAX[gcsr_pkg::SAMPLE_W-1:0];
		else if (gained_s2 < gcsr_pkg::Q3_MIN)
			st = gcsr_pkg::Q3_MIN[gcsr_pkg::SAMPLE_W-1:0];
		else
			st = gained_s2[gcsr_pkg::SAMPLE_W-1:0];
	end

	assign age_rem  = age_s2 - gcsr_pkg::AGE_W'(q_s2 * DEPTH);
	assign age_wide = {{PW{1'b0}}, age_rem};

	// stage 3: limited, saturated and reduced values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s3.valid <= ctl_s2.valid;
			ctl_s3.rd    <= ctl_s2.rd;
			ctl_s3.ch    <= ctl_s2.ch;
			ctl_s3.clip  <= over || under;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lim_s3     <= lim;
			st_s3      <= st;
			age_mod_s3 <= age_wide[PW-1:0];
		end
	end

endmodule

FILE: rtl/gcsr_ring.sv
// Per-channel capture ring: one synchronous memory, write pointers and wrap flags.
// Depends on gcsr_pkg.
module gcsr_ring #(
	parameter int DEPTH = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  gcsr_pkg::ctl_t                  ctl_s3,
	input  logic [gcsr_pkg::SAMPLE_W-1:0]   st_s3,
	input  logic [$clog2(DEPTH)-1:0]        age_mod_s3,
	output logic [gcsr_pkg::ENTRY_W-1:0]    rdata_s4,
	output logic                            rdv_s4
);

	localparam int PW = $clog2(DEPTH);

	logic [gcsr_pkg::ENTRY_W-1:0] mem [2][DEPTH];
	logic [PW-1:0]                wp_q [2];
	logic                         wrap_q [2];
	logic [PW-1:0]                wp_cur;
	logic [PW:0]                  diff;
	logic [PW:0]                  diff_fix;
	logic [PW-1:0]                ridx;
	logic                         we;

	assign wp_cur   = wp_q[ctl_s3.ch];
	assign diff     = {1'b0, wp_cur} - {1'b0, age_mod_s3};
	assign diff_fix = diff[PW] ? diff + (PW+1)'(DEPTH) : diff;
	assign ridx     = diff_fix[PW-1:0];
	assign we       = adv && ctl_s3.valid && !ctl_s3.rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q[0]   <= '0;
			wp_q[1]   <= '0;
			wrap_q[0] <= 1'b0;
			wrap_q[1] <= 1'b0;
			rdv_s4    <= 1'b0;
		end else begin
			if (we) begin
				if (wp_cur == PW'(DEPTH - 1)) begin
					wp_q[ctl_s3.ch]   <= '0;
					wrap_q[ctl_s3.ch] <= 1'b1;
				end else begin
					wp_q[ctl_s3.ch] <= wp_cur + PW'(1);
				end
			end
			if (adv) begin
				rdv_s4 <= wrap_q[ctl_s3.ch] || (ridx < wp_cur);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (we) begin
				mem[ctl_s3.ch][wp_cur] <= {ctl_s3.clip, st_s3};
			end else begin
				rdata_s4 <= mem[ctl_s3.ch][ridx];
			end
		end
	end

endmodule

FILE: rtl/gain_clip_stage_with_capture_ring_unit.sv
// Two-channel gain / hard-clip stage with a per-channel capture ring of
// HISTORY_DEPTH entries. A process beat (req_type 0) returns the sample scaled by
// input_gain, limited to +/-1.0 and scaled by output_gain, with its clip flag, and
// logs the gained sample (saturated to Q3.20) in the channel's ring. A read beat
// (req_type 1) returns the entry age positions back; age 1 is the newest, ages wrap
// modulo HISTORY_DEPTH, and unwritten entries read as zero. Each request yields one
// response beat, and a new request is taken every cycle while req_stall is low; the
// pipeline makes one access to the single-port ring memory per request. Gains are
// written over the APB port at byte addresses 0 and 4 while idle.
module gain_clip_stage_with_capture_ring_unit #(
	parameter int HISTORY_DEPTH = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [gcsr_pkg::ADDR_W-1:0]          paddr,
	input  logic [gcsr_pkg::DATA_W-1:0]          pwdata,
	output logic [gcsr_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic                                 req_type,
	input  logic                                 channel,
	input  logic signed [gcsr_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [gcsr_pkg::AGE_W-1:0]           age,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic signed [gcsr_pkg::OUT_W-1:0]    sample_out,
	output logic                                 clipped,
	output logic signed [gcsr_pkg::SAMPLE_W-1:0] history_sample,
	output logic                                 history_clipped
);

	localparam int PW     = $clog2(HISTORY_DEPTH);
	localparam int YPROD_W = gcsr_pkg::LIM_W + gcsr_pkg::GAIN_W + 1;

	logic [gcsr_pkg::GAIN_W-1:0]          input_gain;
	logic [gcsr_pkg::GAIN_W-1:0]          output_gain;
	logic                                 adv;
	logic                                 acc;
	gcsr_pkg::ctl_t                       ctl_s3;
	logic signed [gcsr_pkg::LIM_W-1:0]    lim_s3;
	logic [gcsr_pkg::SAMPLE_W-1:0]        st_s3;
	logic [PW-1:0]                        age_mod_s3;
	logic [gcsr_pkg::ENTRY_W-1:0]         rdata_s4;
	logic                                 rdv_s4;
	gcsr_pkg::ctl_t                       ctl_s4;
	logic signed [YPROD_W-1:0]            yprod;
	logic signed [YPROD_W-1:0]            yprod_s4;
	logic signed [YPROD_W-1:0]            y_rnd;
	logic                                 rsp_valid_q;
	logic signed [gcsr_pkg::OUT_W-1:0]    sample_out_q;
	logic                                 clipped_q;
	logic signed [gcsr_pkg::SAMPLE_W-1:0] hist_sample_q;
	logic                                 hist_clipped_q;

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign acc       = req_valid && adv;
	assign req_stall = !adv;

	gcsr_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.input_gain  (input_gain),
		.output_gain (output_gain)
	);

	gcsr_front #(
		.DEPTH (HISTORY_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.acc        (acc),
		.req_type   (req_type),
		.channel    (channel),
		.sample_in  (sample_in),
		.age        (age),
		.input_gain (input_gain),
		.ctl_s3     (ctl_s3),
		.lim_s3     (lim_s3),
		.st_s3      (st_s3),
		.age_mod_s3 (age_mod_s3)
	);

	gcsr_ring #(
		.DEPTH (HISTORY_DEPTH)
	) u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.ctl_s3     (ctl_s3),
		.st_s3      (st_s3),
		.age_mod_s3 (age_mod_s3),
		.rdata_s4   (rdata_s4),
		.rdv_s4     (rdv_s4)
	);

	assign yprod = lim_s3 * $signed({1'b0, output_gain});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (adv) begin
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			yprod_s4 <= yprod;
		end
	end

	assign y_rnd = yprod_s4 + YPROD_W'(2048);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= ctl_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ctl_s4.rd) begin
				sample_out_q   <= '0;
				clipped_q      <= 1'b0;
				hist_sample_q  <= rdv_s4 ? rdata_s4[gcsr_pkg::SAMPLE_W-1:0] : '0;
				hist_clipped_q <= rdv_s4 && rdata_s4[gcsr_pkg::SAMPLE_W];
			end else begin
				sample_out_q   <= y_rnd[gcsr_pkg::OUT_W+11:12];
				clipped_q      <= ctl_s4.clip;
				hist_sample_q  <= '0;
				hist_clipped_q <= 1'b0;
			end
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign sample_out      = sample_out_q;
	assign clipped         = clipped_q;
	assign history_sample  = hist_sample_q;
	assign history_clipped = hist_clipped_q;

endmodule

FILE: bench/gcsr_clip_ring_check.sv
// Checker for the gain / clip stage with capture ring: watches the APB port and
// both beat channels, predicts each response and compares it field by field.
// Depends on gcsr_pkg for widths, full-scale limits and the request and register codes.
module gcsr_clip_ring_check #(
	parameter int HISTORY_DEPTH = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [gcsr_pkg::ADDR_W-1:0]          paddr,
	input  logic [gcsr_pkg::DATA_W-1:0]          pwdata,
	input  logic [gcsr_pkg::DATA_W-1:0]          prdata,
	input  logic                                 pready,
	input  logic                                 req_valid,
	input  logic                                 req_stall,
	input  logic                                 req_type,
	input  logic                                 channel,
	input  logic signed [gcsr_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [gcsr_pkg::AGE_W-1:0]           age,
	input  logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	input  logic signed [gcsr_pkg::OUT_W-1:0]    sample_out,
	input  logic                                 clipped,
	input  logic signed [gcsr_pkg::SAMPLE_W-1:0] history_sample,
	input  logic                                 history_clipped,
	output int                                   mismatches,
	output int                                   outstanding
);
	import gcsr_pkg::*;

	typedef struct packed {
		logic [OUT_W-1:0]    sample_out;
		logic                clipped;
		logic [SAMPLE_W-1:0] history_sample;
		logic                history_clipped;
	} result_t;

	logic [GAIN_W-1:0]  in_gain;
	logic [GAIN_W-1:0]  out_gain;
	logic [ENTRY_W-1:0] ring [2][HISTORY_DEPTH];
	int                 wr_ptr [2];
	result_t            results_due [$];

	function automatic longint round_q12(longint p);
		return (p + 2048) >>> 12;
	endfunction

	function automatic result_t clip_and_gain(logic signed [SAMPLE_W-1:0] s,
			output logic [ENTRY_W-1:0] entry);
		longint  gained;
		longint  limited;
		longint  stored;
		result_t r;
		gained  = round_q12(longint'(s) * longint'(in_gain));
		limited = gained > FULL_SCALE_POS ? FULL_SCALE_POS
			: (gained < FULL_SCALE_NEG ? FULL_SCALE_NEG : gained);
		stored  = gained > Q3_MAX ? Q3_MAX : (gained < Q3_MIN ? Q3_MIN : gained);
		r = '0;
		r.sample_out = OUT_W'(round_q12(limited * longint'(out_gain)));
		r.clipped    = (gained != limited);
		entry = {r.clipped, stored[SAMPLE_W-1:0]};
		return r;
	endfunction

	function automatic result_t ring_lookup(logic ch, logic [AGE_W-1:0] back);
		logic [ENTRY_W-1:0] entry;
		result_t            r;
		entry = ring[ch][(wr_ptr[ch] + HISTORY_DEPTH - int'(back) % HISTORY_DEPTH)
			% HISTORY_DEPTH];
		r = '0;
		r.history_sample  = entry[SAMPLE_W-1:0];
		r.history_clipped = entry[SAMPLE_W];
		return r;
	endfunction

	task automatic compare_field(string name, logic signed [31:0] want,
			logic signed [31:0] seen);
		if (seen !== want) begin
			mismatches++;
			$error("%s: expected %0d, got %0d", name, want, seen);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t            want;
		logic [ENTRY_W-1:0] entry;
		if (!arst_n) begin
			in_gain  = UNITY_GAIN;
			out_gain = UNITY_GAIN;
			foreach (ring[c, i]) ring[c][i] = '0;
			wr_ptr[0] = 0;
			wr_ptr[1] = 0;
			results_due.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (results_due.size() == 0) begin
					mismatches++;
					$error("response beat with no request outstanding");
				end else begin
					want = results_due.pop_front();
					compare_field("sample_out", $signed(want.sample_out), sample_out);
					compare_field("clipped", want.clipped, clipped);
					compare_field("history_sample", $signed(want.history_sample),
						history_sample);
					compare_field("history_clipped", want.history_clipped, history_clipped);
				end
			end
			if (psel && penable && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_INPUT_GAIN: begin
						if (pwrite) in_gain = pwdata[GAIN_W-1:0];
						else compare_field("prdata", in_gain, prdata[GAIN_W-1:0]);
					end
					REG_OUTPUT_GAIN: begin
						if (pwrite) out_gain = pwdata[GAIN_W-1:0];
						else compare_field("prdata", out_gain, prdata[GAIN_W-1:0]);
					end
				endcase
			end
			if (req_valid && !req_stall) begin
				if (req_type == REQ_PROCESS) begin
					want = clip_and_gain(sample_in, entry);
					ring[channel][wr_ptr[channel]] = entry;
					wr_ptr[channel] = (wr_ptr[channel] + 1) % HISTORY_DEPTH;
				end else begin
					want = ring_lookup(channel, age);
				end
				results_due = {results_due, want};
			end
		end
		outstanding = results_due.size();
	end

endmodule

FILE: bench/tb.sv
// Top of the bench for the gain / clip stage with capture ring: clock, reset,
// APB gain writes, request beats and response stalls, and the final verdict.
// Depends on gcsr_pkg, the block itself and gcsr_clip_ring_check.
module tb;
	import gcsr_pkg::*;

	localparam int HISTORY_DEPTH    = 4096;
	localparam int PHASES           = 7;
	localparam int RANDOM_PER_PHASE = 175;
	localparam int HOLD_AT          = 1500;
	localparam int HOLD_LEN         = 300;

	logic                       clk             = 1'b0;
	logic                       arst_n          = 1'b0;
	logic                       psel            = 1'b0;
	logic                       penable         = 1'b0;
	logic                       pwrite          = 1'b0;
	logic [ADDR_W-1:0]          paddr           = '0;
	logic [DATA_W-1:0]          pwdata          = '0;
	logic [DATA_W-1:0]          prdata;
	logic                       pready;
	logic                       req_valid       = 1'b0;
	logic                       req_stall;
	logic                       req_type        = 1'b0;
	logic                       channel         = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_in       = '0;
	logic [AGE_W-1:0]           age             = '0;
	logic                       rsp_valid;
	logic                       rsp_stall       = 1'b0;
	logic signed [OUT_W-1:0]    sample_out;
	logic                       clipped;
	logic signed [SAMPLE_W-1:0] history_sample;
	logic                       history_clipped;

	int                mismatches;
	int                outstanding;
	int                burst_left  = 0;
	logic [GAIN_W-1:0] cur_in_gain = UNITY_GAIN;

	gain_clip_stage_with_capture_ring_unit #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_dut (.*);

	gcsr_clip_ring_check #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(30, 100);
			return 0;
		end
		if (r < 58) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] edge_sample();
		longint t;
		t = cur_in_gain == 0 ? 1048576 : (longint'(1048576) * 4096) / cur_in_gain;
		t = t + int'($urandom_range(0, 4)) - 2;
		if ($urandom_range(0, 1)) t = -t;
		if ($urandom_range(0, 3) == 0) t = $urandom_range(0, 1) ? 8388607 : -8388608;
		if (t > 8388607) t = 8388607;
		if (t < -8388608) t = -8388608;
		return SAMPLE_W'(t);
	endfunction

	task automatic send(req_kind_t kind, logic ch, logic signed [SAMPLE_W-1:0] s,
			logic [AGE_W-1:0] back);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
			req_type  <= 1'($urandom);
			channel   <= 1'($urandom);
			sample_in <= SAMPLE_W'($urandom);
			age       <= AGE_W'($urandom);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req_type  <= kind;
		channel   <= ch;
		sample_in <= s;
		age       <= back;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic random_item();
		logic signed [SAMPLE_W-1:0] s;
		logic [AGE_W-1:0]           a;
		s = SAMPLE_W'($urandom);
		a = AGE_W'($urandom);
		if ($urandom_range(0, 99) < 60) begin
			case ($urandom_range(0, 3))
				0: s = SAMPLE_W'(int'($urandom_range(0, 4194304)) - 2097152);
				1: s = edge_sample();
				default: ;
			endcase
			send(REQ_PROCESS, 1'($urandom), s, a);
		end else begin
			case ($urandom_range(0, 4))
				0, 1, 2: a = AGE_W'($urandom_range(1, 64));
				3: a = AGE_W'($urandom_range(1, 8));
				default: ;
			endcase
			send(REQ_READ, 1'($urandom), s, a);
		end
	endtask

	task automatic apb_access(logic wr, reg_idx_t idx, logic [GAIN_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= {16'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	initial begin : rx_side
		logic lvl;
		int   left;
		int   cyc;
		bit   held;
		left = 0;
		cyc  = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (left == 0) begin
				int r;
				r = $urandom_range(0, 99);
				if (!held && cyc >= HOLD_AT) begin
					held = 1'b1;
					lvl  = 1'b1;
					left = HOLD_LEN;
				end else if (r < 4) begin
					lvl  = 1'b0;
					left = $urandom_range(40, 120);
				end else if (r < 64) begin
					lvl  = 1'b0;
					left = $urandom_range(1, 4);
				end else if (r < 94) begin
					lvl  = 1'b1;
					left = $urandom_range(1, 3);
				end else begin
					lvl  = 1'b1;
					left = $urandom_range(8, 40);
				end
			end
			rsp_stall <= lvl;
			left--;
		end
	end

	initial begin : stimulus
		logic [GAIN_W-1:0] ig;
		logic [GAIN_W-1:0] og;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send(REQ_READ, 1'b0, '0, 13'd1);
		send(REQ_READ, 1'b1, '0, 13'd0);
		send(REQ_PROCESS, 1'b0, SAMPLE_W'(8388607), 13'd0);
		send(REQ_PROCESS, 1'b0, SAMPLE_W'(-8388608), 13'd8191);
		send(REQ_PROCESS, 1'b0, SAMPLE_W'(1048576), 13'd0);
		send(REQ_PROCESS, 1'b0, SAMPLE_W'(1048577), 13'd0);
		send(REQ_PROCESS, 1'b0, SAMPLE_W'(-1048576), 13'd0);
		send(REQ_PROCESS, 1'b0, SAMPLE_W'(-1048577), 13'd0);
		send(REQ_PROCESS, 1'b1, SAMPLE_W'(0), 13'd0);
		send(REQ_PROCESS, 1'b1, SAMPLE_W'(-1), 13'd0);
		send(REQ_PROCESS, 1'b1, SAMPLE_W'(1), 13'd0);
		send(REQ_READ, 1'b0, SAMPLE_W'(-1), 13'd1);
		send(REQ_READ, 1'b0, '0, 13'd6);
		send(REQ_READ, 1'b0, '0, 13'd4096);
		send(REQ_READ, 1'b0, '0, 13'd0);
		send(REQ_READ, 1'b0, '0, 13'd4097);
		send(REQ_READ, 1'b0, '0, 13'd8191);
		send(REQ_READ, 1'b1, '0, 13'd3);
		send(REQ_READ, 1'b1, '0, 13'd2);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain();
				case (ph)
					1: begin ig = 16'hFFFF; og = 16'hFFFF; end
					2: begin ig = 16'h0000; og = 16'h0000; end
					3: begin ig = 16'h0001; og = 16'hFFFF; end
					4: begin ig = 16'h3000; og = 16'h0800; end
					default: begin
						ig = GAIN_W'($urandom);
						og = GAIN_W'($urandom);
					end
				endcase
				apb_access(1'b1, REG_INPUT_GAIN, ig);
				apb_access(1'b1, REG_OUTPUT_GAIN, og);
				apb_access(1'b0, REG_INPUT_GAIN, '0);
				apb_access(1'b0, REG_OUTPUT_GAIN, '0);
				cur_in_gain = ig;
			end
			repeat (RANDOM_PER_PHASE) random_item();
		end

		drain();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin : watchdog
		#10000000;
		$display("status: fail");
		$finish;
	end

endmodule

FILE: sim.f
rtl/gcsr_pkg.sv
rtl/gcsr_regs.sv
rtl/gcsr_front.sv
rtl/gcsr_ring.sv
rtl/gain_clip_stage_with_capture_ring_unit.sv
bench/gcsr_clip_ring_check.sv
bench/tb.sv
